// ===== rtl/core/dual_moving_average_alarm_core_macros.svh =====
// Assertion helpers used by the checker file of this block.
`ifndef DUAL_MOVING_AVERAGE_ALARM_CORE_MACROS_SVH
`define DUAL_MOVING_AVERAGE_ALARM_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dma_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 16;
	localparam int AVG_W      = 12;
	localparam int DIV_CNT_W  = $clog2(AVG_W);
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_ALARM_LEVEL_CH0 = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_ALARM_LEVEL_CH1 = CFG_ADDR_W'(1);

	localparam logic [CFG_DATA_W-1:0] ALARM_LEVEL_RESET = '1;

endpackage

`default_nettype wire

// ===== rtl/core/dma_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dma_ring #(
	parameter int WINDOW = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [dma_pkg::SAMPLE_W-1:0]     sample_ch0,
	input  logic [dma_pkg::SAMPLE_W-1:0]     sample_ch1,
	output logic [dma_pkg::SUM_W-1:0]        sum_ch0,
	output logic [dma_pkg::SUM_W-1:0]        sum_ch1,
	output logic [$clog2(WINDOW+1)-1:0]      fill_count
);
	import dma_pkg::*;

	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);

	logic [SAMPLE_W-1:0] ring_ch0_q [WINDOW];
	logic [SAMPLE_W-1:0] ring_ch1_q [WINDOW];
	logic [SUM_W-1:0]    sum_ch0_q;
	logic [SUM_W-1:0]    sum_ch1_q;
	logic [POS_W-1:0]    pos_q;
	logic [FILL_W-1:0]   fill_q;

	logic [SAMPLE_W-1:0] old_ch0;
	logic [SAMPLE_W-1:0] old_ch1;

	assign old_ch0 = ring_ch0_q[pos_q];
	assign old_ch1 = ring_ch1_q[pos_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_ch0_q[i] <= '0;
				ring_ch1_q[i] <= '0;
			end
			sum_ch0_q <= '0;
			sum_ch1_q <= '0;
			pos_q     <= '0;
			fill_q    <= '0;
		end else if (push) begin
			// The oldest entry leaves the window as the new sample enters it.
			sum_ch0_q <= sum_ch0_q - SUM_W'(old_ch0) + SUM_W'(sample_ch0);
			sum_ch1_q <= sum_ch1_q - SUM_W'(old_ch1) + SUM_W'(sample_ch1);
			ring_ch0_q[pos_q] <= sample_ch0;
			ring_ch1_q[pos_q] <= sample_ch1;
			if (pos_q == POS_W'(WINDOW - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (fill_q != FILL_W'(WINDOW)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign sum_ch0    = sum_ch0_q;
	assign sum_ch1    = sum_ch1_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire

// ===== rtl/core/dma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dma_div #(
	parameter int FILL_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dma_pkg::SUM_W-1:0]  dividend,
	input  logic [FILL_W-1:0]          divisor,
	output logic                       done,
	output logic [dma_pkg::AVG_W-1:0]  quotient
);
	import dma_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FILL_W-1:0]    rem_q;
	logic [AVG_W-1:0]     dq_q;

	logic [SUM_W-1:0]     dividend_hi;
	logic [FILL_W:0]      trial;
	logic [FILL_W:0]      diff;
	logic                 fits;

	// The windowed sum never exceeds fill * 4095, so the quotient fits in
	// AVG_W bits and the bits above them start out as a partial remainder
	// that is already below the divisor.
	assign dividend_hi = dividend >> AVG_W;

	assign trial = {rem_q, dq_q[AVG_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(AVG_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(AVG_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle; quotient bits shift in
	// where the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi[FILL_W-1:0];
			dq_q  <= dividend[AVG_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
			dq_q  <= {dq_q[AVG_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

// ===== rtl/core/dual_moving_average_alarm_core.sv =====
// One request is processed at a time: s_tready is low from acceptance until the result
// is handed to the output register. A single shared restoring divider
// produces one quotient bit per cycle, 12 bits for each of the two channels.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) clears both sample windows, the sums, the write
// position and the fill count, and sets both alarm levels to 4095.
`timescale 1ns / 1ps
`default_nettype none

module dual_moving_average_alarm_core #(
	parameter int WINDOW = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: [11:0] sample_ch0, [23:12] sample_ch1
	input  logic [dma_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: [11:0] average_ch0, [23:12] average_ch1, [24] alarm_flag, [31:25] zero
	output logic [dma_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_we,
	input  logic [dma_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [dma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import dma_pkg::*;

	localparam int FILL_W = $clog2(WINDOW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START0,
		ST_WAIT0,
		ST_START1,
		ST_WAIT1,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [AVG_W-1:0]     avg_ch0_q;
	logic [AVG_W-1:0]     avg_ch1_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [CFG_DATA_W-1:0] level_ch0_q;
	logic [CFG_DATA_W-1:0] level_ch1_q;

	logic                 push;
	logic [SUM_W-1:0]     sum_ch0;
	logic [SUM_W-1:0]     sum_ch1;
	logic [FILL_W-1:0]    fill_count;
	logic                 div_start;
	logic [SUM_W-1:0]     div_dividend;
	logic                 div_done;
	logic [AVG_W-1:0]     div_quotient;
	logic                 alert;

	assign s_tready = (state_q == ST_IDLE);
	assign push     = s_tvalid && s_tready;

	dma_ring #(
		.WINDOW(WINDOW)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample_ch0(s_tdata[SAMPLE_W-1:0]),
		.sample_ch1(s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.sum_ch0   (sum_ch0),
		.sum_ch1   (sum_ch1),
		.fill_count(fill_count)
	);

	assign div_start    = (state_q == ST_START0) || (state_q == ST_START1);
	assign div_dividend = (state_q == ST_START1) ? sum_ch1 : sum_ch0;

	dma_div #(
		.FILL_W(FILL_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (fill_count),
		.done    (div_done),
		.quotient(div_quotient)
	);

	assign alert = (avg_ch0_q > level_ch0_q) || (avg_ch1_q > level_ch1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_ch0_q <= ALARM_LEVEL_RESET;
			level_ch1_q <= ALARM_LEVEL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ALARM_LEVEL_CH0: level_ch0_q <= cfg_wdata;
				REG_ALARM_LEVEL_CH1: level_ch1_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			avg_ch0_q  <= '0;
			avg_ch1_q  <= '0;
		end else begin
			// In ST_OUT an accepted result is replaced by the new one below.
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q <= ST_START0;
					end
				end
				ST_START0: state_q <= ST_WAIT0;
				ST_WAIT0: begin
					if (div_done) begin
						avg_ch0_q <= div_quotient;
						state_q   <= ST_START1;
					end
				end
				ST_START1: state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (div_done) begin
						avg_ch1_q <= div_quotient;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hand over only once the output register is free this cycle.
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({alert, avg_ch1_q, avg_ch0_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/dma_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dual_moving_average_alarm_core_macros.svh"

module dma_chk (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	input  wire                             s_tready,
	input  wire                             m_tvalid,
	input  wire                             m_tready,
	input  wire [dma_pkg::M_TDATA_W-1:0]    m_tdata
);
	import dma_pkg::*;

	// A stalled result keeps its contents.
	`DMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Each accepted request makes the block busy, so no request is taken straight behind it.
	`DMA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A new result appears exactly when the sequencer returns to idle.
	`DMA_ASSERT_NOW(a_result_idle, $rose(m_tvalid), s_tready, "result offered while still busy")

	// Bits above the result fields are padding.
	`DMA_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:2*AVG_W+1] == '0, "padding bits set")

endmodule

bind dual_moving_average_alarm_core dma_chk u_dma_chk (.*);

`default_nettype wire
